>>> hdl/lobm_pkg.sv
package lobm_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        order_side;
		logic [31:0] limit_price;
		logic [31:0] order_qty;
		logic [31:0] target_id;
	} order_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] report_price;
		logic [31:0] report_qty;
		logic [31:0] report_id;
		logic        book_side;
		logic        last;
	} report_t;

	typedef struct packed {
		logic [31:0] price;
		logic [31:0] qty;
		logic [31:0] id;
	} entry_t;

	localparam logic [1:0] CMD_LIMIT  = 2'd0;
	localparam logic [1:0] CMD_MARKET = 2'd1;
	localparam logic [1:0] CMD_CANCEL = 2'd2;
	localparam logic [1:0] CMD_CHANGE = 2'd3;

	localparam logic [2:0] KIND_TRADE    = 3'd0;
	localparam logic [2:0] KIND_ACCEPT   = 3'd1;
	localparam logic [2:0] KIND_CANCEL   = 3'd2;
	localparam logic [2:0] KIND_NOTFOUND = 3'd3;
	localparam logic [2:0] KIND_FULL     = 3'd4;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_LIM_START, OP_MKT_START, OP_FIND_START,
		OP_INS_RD, OP_INS_NEW, OP_INS_SHIFT,
		OP_F_RD, OP_F_NEXT, OP_F_NEXTSIDE, OP_F_HIT,
		OP_R_RD, OP_R_WR, OP_R_DONE, OP_CHG_START,
		OP_SW_RD, OP_SW_CHK, OP_SW_UPD
	} op_t;

	typedef enum logic [2:0] {
		EM_TRADE, EM_ACCEPT, EM_CANCEL, EM_NOTFOUND, EM_FULL
	} emit_sel_t;

	typedef struct packed {
		op_t       op;
		logic      emit;
		emit_sel_t esel;
		logic      flush;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       full;
		logic       idx_zero;
		logic       ins_front;
		logic       f_end;
		logic       id_hit;
		logic       side_one;
		logic       r_last;
		logic       sw_go;
		logic       sw_cross;
		logic       sw_split;
		logic       open;
		logic       out_free;
	} dp_st_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic pop;
		logic inc;
		logic dec;
	} book_ctl_t;

endpackage

>>> hdl/lobm_book.sv
module lobm_book import lobm_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW = $clog2(DEPTH),
	parameter int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  book_ctl_t     ctl,
	input  logic [CW-1:0] rd_idx,
	input  logic [CW-1:0] wr_idx,
	input  entry_t        wr_data,
	output entry_t        rdata,
	output logic [CW-1:0] count
);

	entry_t         mem [DEPTH];
	entry_t         rdata_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic [AW:0]    rsum, wsum;
	logic [AW-1:0]  raddr, waddr;

	// ring buffer: logical index is offset from head, wrapped at DEPTH
	always_comb begin
		rsum = {1'b0, head_q} + (AW+1)'(rd_idx);
		wsum = {1'b0, head_q} + (AW+1)'(wr_idx);
		if (rsum >= (AW+1)'(DEPTH)) begin
			rsum = rsum - (AW+1)'(DEPTH);
		end
		if (wsum >= (AW+1)'(DEPTH)) begin
			wsum = wsum - (AW+1)'(DEPTH);
		end
		raddr = rsum[AW-1:0];
		waddr = wsum[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[waddr] <= wr_data;
		end
		if (ctl.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end else if (ctl.inc) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rdata = rdata_q;
	assign count = count_q;

endmodule

>>> hdl/lobm_datapath.sv
module lobm_datapath import lobm_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	output dp_st_t  st,
	input  order_t  order,
	output report_t report,
	output logic    report_valid,
	input  logic    report_stall
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	order_t        item_q;
	logic          side_q, rsd_q, mkt_q, open_q;
	logic [CW-1:0] idx_q;
	entry_t        new_q, found_q;
	logic [31:0]   rem_q, cur_q, acc_q, f_q, next_id_q;
	report_t       pend_q, out_q, em, promote_d;
	logic          pend_v_q, out_v_q;

	book_ctl_t     bctl  [2];
	logic [CW-1:0] brd   [2];
	logic [CW-1:0] bwr   [2];
	entry_t        bwd   [2];
	entry_t        rdat  [2];
	logic [CW-1:0] cnt   [2];

	entry_t        top_r, top_o;
	logic [31:0]   other_qty, nq_r, nq_o;

	for (genvar s = 0; s < 2; s++) begin : g_book
		lobm_book #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_book (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (bctl[s]),
			.rd_idx (brd[s]),
			.wr_idx (bwr[s]),
			.wr_data(bwd[s]),
			.rdata  (rdat[s]),
			.count  (cnt[s])
		);
	end

	always_comb begin
		top_r     = rdat[rsd_q];
		top_o     = rdat[~rsd_q];
		other_qty = mkt_q ? rem_q : top_o.qty;
		nq_r      = top_r.qty - f_q;
		nq_o      = top_o.qty - f_q;
	end

	// per-side memory requests
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			bctl[s] = '0;
			brd[s]  = '0;
			bwr[s]  = idx_q;
			bwd[s]  = rdat[s];
		end
		unique case (cmd.op)
			OP_INS_RD: begin
				bctl[side_q].rd = 1'b1;
				brd[side_q]     = idx_q - CW'(1);
			end
			OP_INS_NEW: begin
				bctl[side_q].wr  = 1'b1;
				bctl[side_q].inc = 1'b1;
				bwd[side_q]      = new_q;
			end
			OP_INS_SHIFT, OP_R_WR: begin
				bctl[side_q].wr = 1'b1;
			end
			OP_F_RD: begin
				bctl[side_q].rd = 1'b1;
				brd[side_q]     = idx_q;
			end
			OP_R_RD: begin
				bctl[side_q].rd = 1'b1;
				brd[side_q]     = idx_q + CW'(1);
			end
			OP_R_DONE: begin
				bctl[side_q].dec = 1'b1;
			end
			OP_SW_RD: begin
				bctl[0].rd = 1'b1;
				bctl[1].rd = 1'b1;
			end
			OP_SW_UPD: begin
				bwr[0] = '0;
				bwr[1] = '0;
				if (nq_r == '0) begin
					bctl[rsd_q].pop = 1'b1;
				end else begin
					bctl[rsd_q].wr = 1'b1;
					bwd[rsd_q]     = '{price: top_r.price, qty: nq_r, id: top_r.id};
				end
				if (!mkt_q) begin
					if (nq_o == '0) begin
						bctl[~rsd_q].pop = 1'b1;
					end else begin
						bctl[~rsd_q].wr = 1'b1;
						bwd[~rsd_q]     = '{price: top_o.price, qty: nq_o, id: top_o.id};
					end
				end
			end
			default: ;
		endcase
	end

	// result formed from the selected source
	always_comb begin
		em = '0;
		unique case (cmd.esel)
			EM_TRADE: begin
				em.kind         = KIND_TRADE;
				em.report_price = cur_q;
				em.report_qty   = acc_q;
				em.book_side    = rsd_q;
			end
			EM_ACCEPT: begin
				em.kind         = KIND_ACCEPT;
				em.report_price = new_q.price;
				em.report_qty   = new_q.qty;
				em.report_id    = new_q.id;
				em.book_side    = side_q;
			end
			EM_CANCEL: begin
				em.kind         = KIND_CANCEL;
				em.report_price = found_q.price;
				em.report_qty   = found_q.qty;
				em.report_id    = item_q.target_id;
				em.book_side    = side_q;
			end
			EM_NOTFOUND: begin
				em.kind      = KIND_NOTFOUND;
				em.report_id = item_q.target_id;
			end
			EM_FULL: begin
				em.kind         = KIND_FULL;
				em.report_price = item_q.limit_price;
				em.report_qty   = item_q.order_qty;
				em.book_side    = item_q.order_side;
			end
			default: ;
		endcase
	end

	// pending beat moving to the output stage, marked last on flush
	always_comb begin
		promote_d      = pend_q;
		promote_d.last = cmd.flush;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: item_q <= order;
			OP_LIM_START: begin
				new_q  <= '{price: item_q.limit_price, qty: item_q.order_qty, id: next_id_q};
				side_q <= item_q.order_side;
				idx_q  <= cnt[item_q.order_side];
			end
			OP_MKT_START: begin
				rsd_q  <= ~item_q.order_side;
				rem_q  <= item_q.order_qty;
				mkt_q  <= 1'b1;
				open_q <= 1'b0;
				acc_q  <= '0;
			end
			OP_FIND_START: begin
				side_q <= SIDE_SELL;
				idx_q  <= '0;
			end
			OP_INS_NEW: begin
				rsd_q  <= ~side_q;
				mkt_q  <= 1'b0;
				open_q <= 1'b0;
				acc_q  <= '0;
			end
			OP_INS_SHIFT: idx_q <= idx_q - CW'(1);
			OP_F_NEXT, OP_R_WR: idx_q <= idx_q + CW'(1);
			OP_F_NEXTSIDE: begin
				side_q <= SIDE_BUY;
				idx_q  <= '0;
			end
			OP_F_HIT: found_q <= rdat[side_q];
			OP_CHG_START: begin
				new_q <= '{price: item_q.limit_price, qty: item_q.order_qty,
					id: item_q.target_id};
				idx_q <= cnt[side_q];
			end
			OP_SW_CHK: begin
				f_q    <= (other_qty < top_r.qty) ? other_qty : top_r.qty;
				cur_q  <= top_r.price;
				open_q <= 1'b1;
				if (cmd.emit) begin
					acc_q <= '0;
				end
			end
			OP_SW_UPD: begin
				acc_q <= acc_q + f_q;
				if (mkt_q) begin
					rem_q <= rem_q - f_q;
				end
			end
			default: ;
		endcase
		if (cmd.emit) begin
			pend_q <= em;
		end
		if ((cmd.emit || cmd.flush) && pend_v_q) begin
			out_q <= promote_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_id_q <= 32'd1;
			pend_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cmd.op == OP_LIM_START) begin
				next_id_q <= next_id_q + 32'd1;
			end
			if (cmd.emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if ((cmd.emit || cmd.flush) && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (!report_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		st.cmd       = item_q.cmd;
		st.full      = cnt[item_q.order_side] == CW'(DEPTH);
		st.idx_zero  = idx_q == '0;
		st.ins_front = side_q ? (rdat[1].price <= new_q.price)
			: (rdat[0].price >= new_q.price);
		st.f_end     = idx_q == cnt[side_q];
		st.id_hit    = rdat[side_q].id == item_q.target_id;
		st.side_one  = side_q;
		st.r_last    = (idx_q + CW'(1)) == cnt[side_q];
		st.sw_go     = mkt_q ? (rem_q != '0 && cnt[rsd_q] != '0)
			: (cnt[0] != '0 && cnt[1] != '0);
		st.sw_cross  = mkt_q || (rdat[0].price >= rdat[1].price);
		st.sw_split  = open_q && (top_r.price != cur_q);
		st.open      = open_q;
		st.out_free  = !pend_v_q || !out_v_q || !report_stall;
	end

	assign report       = out_q;
	assign report_valid = out_v_q;

endmodule

>>> hdl/lobm_ctrl.sv
module lobm_ctrl import lobm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    order_valid,
	output logic    order_stall,
	input  dp_st_t  st,
	output dp_cmd_t cmd
);

	typedef enum logic [16:0] {
		S_IDLE     = 17'b00000000000000001,
		S_DISPATCH = 17'b00000000000000010,
		S_FULL     = 17'b00000000000000100,
		S_INS_RD   = 17'b00000000000001000,
		S_INS_CHK  = 17'b00000000000010000,
		S_ACC      = 17'b00000000000100000,
		S_F_RD     = 17'b00000000001000000,
		S_F_CHK    = 17'b00000000010000000,
		S_R_RD     = 17'b00000000100000000,
		S_R_WR     = 17'b00000001000000000,
		S_CAN      = 17'b00000010000000000,
		S_NF       = 17'b00000100000000000,
		S_SW_RD    = 17'b00001000000000000,
		S_SW_CHK   = 17'b00010000000000000,
		S_SW_UPD   = 17'b00100000000000000,
		S_SW_END   = 17'b01000000000000000,
		S_FLUSH    = 17'b10000000000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.op   = OP_NONE;
		cmd.esel = EM_TRADE;
		unique case (state_q)
			S_IDLE: begin
				if (order_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (st.cmd)
					CMD_LIMIT: begin
						if (st.full) begin
							state_d = S_FULL;
						end else begin
							cmd.op  = OP_LIM_START;
							state_d = S_INS_RD;
						end
					end
					CMD_MARKET: begin
						cmd.op  = OP_MKT_START;
						state_d = S_SW_RD;
					end
					default: begin
						cmd.op  = OP_FIND_START;
						state_d = S_F_RD;
					end
				endcase
			end
			S_FULL: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = EM_FULL;
					state_d  = S_FLUSH;
				end
			end
			S_INS_RD: begin
				if (st.idx_zero) begin
					cmd.op  = OP_INS_NEW;
					state_d = S_ACC;
				end else begin
					cmd.op  = OP_INS_RD;
					state_d = S_INS_CHK;
				end
			end
			S_INS_CHK: begin
				if (st.ins_front) begin
					cmd.op  = OP_INS_NEW;
					state_d = S_ACC;
				end else begin
					cmd.op  = OP_INS_SHIFT;
					state_d = S_INS_RD;
				end
			end
			S_ACC: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = EM_ACCEPT;
					state_d  = S_SW_RD;
				end
			end
			S_F_RD: begin
				if (st.f_end) begin
					if (st.side_one) begin
						cmd.op = OP_F_NEXTSIDE;
					end else begin
						state_d = S_NF;
					end
				end else begin
					cmd.op  = OP_F_RD;
					state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				if (st.id_hit) begin
					cmd.op  = OP_F_HIT;
					state_d = S_R_RD;
				end else begin
					cmd.op  = OP_F_NEXT;
					state_d = S_F_RD;
				end
			end
			S_R_RD: begin
				if (st.r_last) begin
					cmd.op  = OP_R_DONE;
					state_d = S_CAN;
				end else begin
					cmd.op  = OP_R_RD;
					state_d = S_R_WR;
				end
			end
			S_R_WR: begin
				cmd.op  = OP_R_WR;
				state_d = S_R_RD;
			end
			S_CAN: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = EM_CANCEL;
					if (st.cmd == CMD_CANCEL) begin
						state_d = S_FLUSH;
					end else begin
						cmd.op  = OP_CHG_START;
						state_d = S_INS_RD;
					end
				end
			end
			S_NF: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = EM_NOTFOUND;
					state_d  = S_FLUSH;
				end
			end
			S_SW_RD: begin
				if (st.sw_go) begin
					cmd.op  = OP_SW_RD;
					state_d = S_SW_CHK;
				end else begin
					state_d = S_SW_END;
				end
			end
			S_SW_CHK: begin
				if (!st.sw_cross) begin
					state_d = S_SW_END;
				end else if (st.sw_split) begin
					if (st.out_free) begin
						cmd.op   = OP_SW_CHK;
						cmd.emit = 1'b1;
						cmd.esel = EM_TRADE;
						state_d  = S_SW_UPD;
					end
				end else begin
					cmd.op  = OP_SW_CHK;
					state_d = S_SW_UPD;
				end
			end
			S_SW_UPD: begin
				cmd.op  = OP_SW_UPD;
				state_d = S_SW_RD;
			end
			S_SW_END: begin
				if (!st.open) begin
					state_d = S_FLUSH;
				end else if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.esel = EM_TRADE;
					state_d  = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign order_stall = state_q != S_IDLE;

endmodule

>>> hdl/limit_order_book_matcher.sv
// Price-time priority matching engine with a buy book and a sell book.
// Order channel: order_valid / order_stall carry one order beat (limit,
// market, cancel or change). Report channel: report_valid / report_stall
// carry result beats; report.last marks the final beat of one order.
// One order is in work at a time; order_stall stays high until its last
// report sits in the output register. A report waiting there does not
// block the next order from being taken.
// Each book is a ring buffer in one memory per side, so popping the top
// only moves the head pointer. The work grows with the orders handled:
//   insert: each resting order that ranks behind the new one moves back
//   cancel search: each order scanned (sell book first), then
//   each order behind the removed one shifts down
//   matching: resting orders touched one at a time, one report per price level
// The memory's single read port per side sets the pace of these steps.
// Reset clears both books (counts to zero) and sets the next id to 1;
// memory contents are not cleared and are never read before written.
// A stalled receiver holds the report beat; work pauses only when a
// further report has nowhere to go.
module limit_order_book_matcher import lobm_pkg::*; #(
	parameter int BOOK_DEPTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    order_valid,
	output logic    order_stall,
	input  order_t  order,
	output logic    report_valid,
	input  logic    report_stall,
	output report_t report
);

	dp_cmd_t cmd;
	dp_st_t  st;

	// sequence the micro-operations
	lobm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.order_valid(order_valid),
		.order_stall(order_stall),
		.st         (st),
		.cmd        (cmd)
	);

	// hold the books, the working order and the report stages
	lobm_datapath #(.DEPTH(BOOK_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.order       (order),
		.report      (report),
		.report_valid(report_valid),
		.report_stall(report_stall)
	);

endmodule
